// ----- rtl/c2u_pkg.sv -----
// Shared types and constants of the codepage to Unicode mapper.
package c2u_pkg;

  // Table storage
  localparam int unsigned TableDepthDefault = 32768;
  localparam int unsigned IndexWidth        = 15;
  localparam int unsigned QueueDepth        = 2;

  // Operation codes of an input transaction
  localparam logic OP_CONVERT     = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;

  // Codepage selector codes
  localparam logic [2:0] CP_GBK   = 3'd0;
  localparam logic [2:0] CP_BIG5  = 3'd1;
  localparam logic [2:0] CP_SJIS  = 3'd2;
  localparam logic [2:0] CP_KOREA = 3'd3;
  localparam logic [2:0] CP_THAI  = 3'd4;

  // Row/column bases of the packed table index
  localparam logic [15:0] BASE_COMMON = 16'h4080;
  localparam logic [15:0] BASE_BIG5HI = 16'h6280;
  localparam logic [15:0] BASE_KOREA  = 16'h4180;
  localparam logic [15:0] BASE_THAI   = 16'h0080;
  localparam logic [15:0] BIG5_GAP_LO = 16'h7f00;
  localparam logic [15:0] BIG5_GAP_HI = 16'ha180;

  // Fill and fixed values
  localparam logic [15:0] FILL_QMARK  = 16'h003f;
  localparam logic [15:0] FILL_SJIS   = 16'h30fb;
  localparam logic [15:0] EURO_SIGN   = 16'h20ac;
  localparam logic [15:0] HW_KATAKANA = 16'hff61;
  localparam logic [15:0] THAI_LOW    = 16'h0e01;
  localparam logic [15:0] THAI_HIGH   = 16'h0e3f;

  typedef struct packed {
    logic        op;
    logic [15:0] char_code;
    logic [14:0] table_addr;
    logic [15:0] table_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] unicode_value;
    logic        came_from_table;
  } result_t;

  // What the back end has to do with one queued transaction
  typedef enum logic [1:0] {
    KIND_FIXED  = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_WRITE  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [15:0]           data;
    logic [IndexWidth-1:0] index;
  } entry_t;

endpackage

// ----- rtl/codepage_to_unicode_mapper.sv -----
// Top level of the codepage to Unicode mapper.
//
// The block converts 16-bit GBK, Big5, Shift-JIS, Korean or Thai codes to
// 16-bit Unicode values and takes one transaction per clock cycle without a
// break, conversions and table writes alike. A convert transaction passes
// through the queue between the front end and the back end and then the
// back-end result registers, for a lookup the registered read of the table
// memory, before its result strobe rises; a table write gives no result.
// The rate of one transaction per cycle is set by the single table memory
// port, which serves one read or one write per cycle. The receiver cannot
// stall, so the back end drains the queue every cycle and busy_o does not
// rise in normal use; it only guards the queue.
// The table comes up undefined after reset and there is no clearing pass:
// an entry must be written before a code that indexes it is converted.
// The codepage register may be written at any time the block is idle;
// cfg_ready_o is always high.
module codepage_to_unicode_mapper #(
  parameter int unsigned TABLE_DEPTH = c2u_pkg::TableDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Command channel
  input  logic              start_i,
  output logic              busy_o,
  input  c2u_pkg::in_item_t in_i,
  // Result strobe
  output logic              result_valid_o,
  output c2u_pkg::result_t  result_o,
  // Configuration write channel: codepage selector
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_data_i
);

  c2u_pkg::entry_t front_entry;
  c2u_pkg::entry_t queue_entry;
  logic            accept;
  logic            queue_empty;
  logic            queue_full;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = queue_full;
  assign accept      = start_i && !queue_full;

  // The front end classifies each transaction in the cycle that accepts it:
  // a fixed answer, a table lookup with its packed index, or a table write.
  c2u_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .entry_o     (front_entry)
  );

  // The queue keeps transactions in order, so a lookup always sees every
  // table write that was accepted before it.
  c2u_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .entry_i (front_entry),
    .pop_i   (!queue_empty),
    .entry_o (queue_entry),
    .empty_o (queue_empty),
    .full_o  (queue_full)
  );

  // The back end retires one queued transaction in every cycle that the queue is not empty.
  c2u_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (!queue_empty),
    .entry_i        (queue_entry),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ----- rtl/c2u_front.sv -----
// Front end: codepage register and classification of input transactions.
module c2u_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_data_i,
  input  c2u_pkg::in_item_t in_i,
  output c2u_pkg::entry_t   entry_o
);

  logic [2:0]  cp_q;
  logic [15:0] code;
  logic [7:0]  lo;
  logic [15:0] d_common;
  logic [15:0] d_big5hi;
  logic [15:0] d_korea;
  logic [15:0] d_thai;
  logic [14:0] idx_thai;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q <= c2u_pkg::CP_GBK;
    end else if (cfg_valid_i) begin
      cp_q <= cfg_data_i;
    end
  end

  assign code     = in_i.char_code;
  assign lo       = code[7:0];
  assign d_common = code - c2u_pkg::BASE_COMMON;
  assign d_big5hi = code - c2u_pkg::BASE_BIG5HI;
  assign d_korea  = code - c2u_pkg::BASE_KOREA;
  assign d_thai   = code - c2u_pkg::BASE_THAI;
  // Thai rows are 32 words apart; the column, 0x00..0x1f here, is added to the row base.
  assign idx_thai = 15'({code[15:8], 5'b0_0000}) + 15'(d_thai[6:0]);

  always_comb begin
    entry_o.kind  = c2u_pkg::KIND_FIXED;
    entry_o.data  = '0;
    entry_o.index = '0;
    if (in_i.op == c2u_pkg::OP_TABLE_WRITE) begin
      entry_o.kind  = c2u_pkg::KIND_WRITE;
      entry_o.data  = in_i.table_data;
      entry_o.index = in_i.table_addr;
    end else if (lo <= 8'h7f) begin
      entry_o.data = {8'h00, lo};
    end else begin
      unique case (cp_q)
        c2u_pkg::CP_GBK: begin
          priority if (lo == 8'h80) entry_o.data = c2u_pkg::EURO_SIGN;
          else if (lo == 8'hff) entry_o.data = 16'hf8f5;
          else if (code[15:8] == 8'h00) entry_o.data = '0;
          else if (code < c2u_pkg::BASE_COMMON) entry_o.data = c2u_pkg::FILL_QMARK;
          else begin
            entry_o.kind  = c2u_pkg::KIND_LOOKUP;
            entry_o.index = {d_common[15:8], d_common[6:0]};
          end
        end
        c2u_pkg::CP_BIG5: begin
          priority if (lo == 8'h80) entry_o.data = 16'h0080;
          else if (lo == 8'hff) entry_o.data = 16'hf8f8;
          else if (code[15:8] == 8'h00) entry_o.data = '0;
          else if (code < c2u_pkg::BASE_COMMON ||
                   (code >= c2u_pkg::BIG5_GAP_LO && code < c2u_pkg::BIG5_GAP_HI)) begin
            entry_o.data = c2u_pkg::FILL_QMARK;
          end else if (code < c2u_pkg::BIG5_GAP_LO) begin
            entry_o.kind  = c2u_pkg::KIND_LOOKUP;
            entry_o.index = {d_common[15:8], d_common[6:0]};
          end else begin
            entry_o.kind  = c2u_pkg::KIND_LOOKUP;
            entry_o.index = {d_big5hi[15:8], d_big5hi[6:0]};
          end
        end
        c2u_pkg::CP_SJIS: begin
          priority if (lo == 8'h80) entry_o.data = 16'h0080;
          else if (lo == 8'ha0) entry_o.data = 16'hf8f0;
          else if (lo >= 8'ha1 && lo < 8'he0) begin
            entry_o.data = c2u_pkg::HW_KATAKANA + 16'(lo - 8'ha1);
          end else if (lo == 8'hfd) entry_o.data = 16'hf8f1;
          else if (lo == 8'hfe) entry_o.data = 16'hf8f2;
          else if (lo == 8'hff) entry_o.data = 16'hf8f3;
          else if (code[15:8] == 8'h00) entry_o.data = '0;
          else if (code < c2u_pkg::BASE_COMMON) entry_o.data = c2u_pkg::FILL_SJIS;
          else begin
            // Columns left here are 0x01..0x1f or 0x60..0x7c; dropping bit 6
            // folds the upper run down onto 0x20..0x3c.
            entry_o.kind  = c2u_pkg::KIND_LOOKUP;
            entry_o.index = {1'b0, d_common[15:8], d_common[5:0]};
          end
        end
        c2u_pkg::CP_KOREA: begin
          priority if (lo == 8'h80) entry_o.data = 16'h0080;
          else if (lo == 8'hff) entry_o.data = 16'hf8f7;
          else if (code[15:8] == 8'h00) entry_o.data = '0;
          else if (code < c2u_pkg::BASE_KOREA) entry_o.data = c2u_pkg::FILL_QMARK;
          else begin
            entry_o.kind  = c2u_pkg::KIND_LOOKUP;
            entry_o.index = {d_korea[15:8], d_korea[6:0]};
          end
        end
        c2u_pkg::CP_THAI: begin
          priority if (lo == 8'hff) entry_o.data = 16'hf8c8;
          else if (lo == 8'hfe) entry_o.data = 16'hf8c7;
          else if (lo == 8'hfd) entry_o.data = 16'hf8c6;
          else if (lo == 8'hfc) entry_o.data = 16'hf8c5;
          else if (lo == 8'hde) entry_o.data = 16'hf8c4;
          else if (lo == 8'hdd) entry_o.data = 16'hf8c3;
          else if (lo == 8'hdc) entry_o.data = 16'hf8c2;
          else if (lo == 8'hdb) entry_o.data = 16'hf8c1;
          else if (lo == 8'ha0) entry_o.data = 16'h00a0;
          else if (lo >= 8'ha1 && lo <= 8'hda) begin
            entry_o.data = c2u_pkg::THAI_LOW + 16'(lo - 8'ha1);
          end else if (lo >= 8'hdf) begin
            entry_o.data = c2u_pkg::THAI_HIGH + 16'(lo - 8'hdf);
          end else begin
            entry_o.kind  = c2u_pkg::KIND_LOOKUP;
            entry_o.index = idx_thai;
          end
        end
        default: entry_o.data = '0;
      endcase
    end
  end

endmodule

// ----- rtl/c2u_queue.sv -----
// Short first-in first-out queue between the front end and the back end.
module c2u_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  c2u_pkg::entry_t entry_i,
  input  logic            pop_i,
  output c2u_pkg::entry_t entry_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned Depth = c2u_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  c2u_pkg::entry_t store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/c2u_back.sv -----
// Back end: table memory, table writes and lookups, and the result register.
module c2u_back #(
  parameter int unsigned TABLE_DEPTH = c2u_pkg::TableDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  c2u_pkg::entry_t   entry_i,
  output logic              result_valid_o,
  output c2u_pkg::result_t  result_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CmpW  = $clog2(TABLE_DEPTH + 1);

  logic [15:0] table_mem [TABLE_DEPTH];
  logic        in_range;
  logic        is_write, is_lookup;
  logic        valid_q;
  logic        lookup_q;
  logic        hit_q;
  logic [15:0] fixed_q;
  logic [15:0] rdata_q;

  assign in_range  = CmpW'(entry_i.index) < CmpW'(TABLE_DEPTH);
  assign is_write  = valid_i && (entry_i.kind == c2u_pkg::KIND_WRITE);
  assign is_lookup = valid_i && (entry_i.kind == c2u_pkg::KIND_LOOKUP);

  always_ff @(posedge clk_i) begin
    if (is_write && in_range) begin
      table_mem[AddrW'(entry_i.index)] <= entry_i.data;
    end
    if (is_lookup && in_range) begin
      rdata_q <= table_mem[AddrW'(entry_i.index)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i && (entry_i.kind != c2u_pkg::KIND_WRITE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      lookup_q <= (entry_i.kind == c2u_pkg::KIND_LOOKUP);
      hit_q    <= in_range;
      fixed_q  <= entry_i.data;
    end
  end

  assign result_valid_o                = valid_q;
  assign result_o.came_from_table      = lookup_q;
  assign result_o.unicode_value        = !lookup_q ? fixed_q :
                                         (hit_q ? rdata_q : 16'h0000);

endmodule

// ----- rtl/c2u_checker.sv -----
// Port-level checks of the codepage to Unicode mapper, bound to the top level.
module c2u_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input c2u_pkg::in_item_t in_i,
  input logic              result_valid_o
);

  logic conv_accept;
  logic write_accept;

  assign conv_accept  = start_i && !busy_o && (in_i.op == c2u_pkg::OP_CONVERT);
  assign write_accept = start_i && !busy_o && (in_i.op == c2u_pkg::OP_TABLE_WRITE);

  // A convert transaction yields its result once it has passed the queue and the back-end registers.
  a_conv_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_accept |-> ##2 result_valid_o)
    else $error("convert transaction gave no result after two cycles");

  // A table write never produces a result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_accept |-> ##2 !result_valid_o)
    else $error("table write produced a result");

  // Every result stems from a convert transaction accepted earlier, with reset released.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(conv_accept, 2) && $past(rst_ni, 2))
    else $error("result strobe without a matching convert transaction");

  // The back end drains every cycle, so the block never pushes back.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised although the queue drains every cycle");

endmodule

bind codepage_to_unicode_mapper c2u_checker u_c2u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .in_i           (in_i),
  .result_valid_o (result_valid_o)
);
